// File: design/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg - shared types and constants for the equivalence-class table
// Operation codes, scan modes and the structs passed between the sequencer,
// the scan unit and the table store.
// ----------------------------------------------------------------------------
package ect_pkg;

	localparam int VAR_W    = 6;
	localparam int OP_W     = 3;
	localparam int CNT_W    = 7;
	localparam int VAR_SPAN = 64;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 16;

	localparam logic [OP_W-1:0] OP_REMOVE = 3'd0;
	localparam logic [OP_W-1:0] OP_MERGE  = 3'd1;
	localparam logic [OP_W-1:0] OP_ASSIGN = 3'd2;
	localparam logic [OP_W-1:0] OP_WEAK   = 3'd3;
	localparam logic [OP_W-1:0] OP_RENAME = 3'd4;

	typedef enum logic [1:0] {
		SCAN_COUNT   = 2'd0,
		SCAN_CLEAR   = 2'd1,
		SCAN_RELABEL = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic             rep_en;
		logic             vld_en;
		logic             vld;
		logic [VAR_W-1:0] rep;
		logic [VAR_W-1:0] idx;
	} wr_req_t;

	typedef struct packed {
		logic       start;
		scan_mode_t mode;
	} scan_cmd_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] cnt;
		logic [VAR_W-1:0] min;
	} scan_rsp_t;

endpackage

// File: design/ect_store.sv
// ----------------------------------------------------------------------------
// ect_store - class membership store
// Membership flags in flip-flops cleared by reset, representatives in a
// single-port-write memory. One registered read and one write per cycle.
// ----------------------------------------------------------------------------
module ect_store #(
	parameter int DEPTH = 64,
	parameter int IW    = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IW-1:0]          rd_addr,
	output logic                   rd_vld,
	output logic [ect_pkg::VAR_W-1:0] rd_rep,
	input  ect_pkg::wr_req_t       wr
);
	import ect_pkg::*;

	logic [DEPTH-1:0] vld_q;
	logic [VAR_W-1:0] rep_mem [DEPTH];
	logic             rd_vld_s1;
	logic [VAR_W-1:0] rd_rep_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.vld_en) begin
				vld_q[wr.idx[IW-1:0]] <= wr.vld;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.rep_en) begin
			rep_mem[wr.idx[IW-1:0]] <= wr.rep;
		end
		rd_rep_s1 <= rep_mem[rd_addr];
	end

	assign rd_vld = rd_vld_s1;
	assign rd_rep = rd_rep_s1;

endmodule

// File: design/ect_scan.sv
// ----------------------------------------------------------------------------
// ect_scan - table scan unit
// Walks the table one entry per cycle, matching members of one class, and
// counts them with the smallest index, clears them, or relabels them.
// ----------------------------------------------------------------------------
module ect_scan #(
	parameter int DEPTH = 64,
	parameter int IW    = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ect_pkg::scan_cmd_t        cmd,
	input  logic [ect_pkg::VAR_W-1:0] target,
	input  logic [ect_pkg::VAR_W-1:0] relabel_to,
	input  logic                      rd_vld,
	input  logic [ect_pkg::VAR_W-1:0] rd_rep,
	output logic [IW-1:0]             addr,
	output ect_pkg::wr_req_t          wr,
	output ect_pkg::scan_rsp_t        rsp
);
	import ect_pkg::*;

	logic             run_q;
	logic [IW-1:0]    addr_q;
	scan_mode_t       mode_q;
	logic             pend_s1;
	logic [IW-1:0]    idx_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [IW-1:0]    min_q;
	logic             found_q;
	logic             match;
	logic             last_s1;

	assign match   = pend_s1 && rd_vld && (rd_rep == target);
	assign last_s1 = pend_s1 && (idx_s1 == IW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			addr_q  <= '0;
			mode_q  <= SCAN_COUNT;
			pend_s1 <= 1'b0;
			idx_s1  <= '0;
			cnt_q   <= '0;
			min_q   <= '0;
			found_q <= 1'b0;
		end else begin
			pend_s1 <= run_q;
			idx_s1  <= addr_q;
			if (cmd.start) begin
				run_q   <= 1'b1;
				addr_q  <= '0;
				mode_q  <= cmd.mode;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (run_q) begin
					if (addr_q == IW'(DEPTH - 1)) begin
						run_q <= 1'b0;
					end
					addr_q <= addr_q + 1'b1;
				end
				if (match && mode_q == SCAN_COUNT) begin
					cnt_q <= cnt_q + 1'b1;
					if (!found_q) begin
						min_q   <= idx_s1;
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		wr     = '0;
		wr.idx = VAR_W'(idx_s1);
		wr.rep = relabel_to;
		case (mode_q)
			SCAN_CLEAR:   wr.vld_en = match;
			SCAN_RELABEL: wr.rep_en = match;
			default:      wr.rep_en = 1'b0;
		endcase
	end

	assign addr     = addr_q;
	assign rsp.done = last_s1;
	assign rsp.cnt  = cnt_q;
	assign rsp.min  = VAR_W'(min_q);

endmodule

// File: design/equivalence_class_table.sv
// ----------------------------------------------------------------------------
// equivalence_class_table - equivalence classes over numbered variables
// Each operation transfer edits the classes; one result transfer per input
// reports the class of var_a afterwards (member flag, representative, size).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries {var_b, var_a, op}; m_axis carries {size, rep, in_class}.
//   One operation is in flight at a time: s_axis_tready is high only while
//   the sequencer is idle. Each operation reads the table, then runs full
//   table scans through the scan unit at one entry per cycle over D =
//   min(VAR_COUNT, 64) entries: one to count a class, one to clear or
//   relabel it. A rename that reshapes two classes is the worst case.
//   The result sits in an output register, so a new operation is accepted
//   while it waits; a stalled m_axis holds the sequencer in its final state
//   until the register frees up.
//   Reset empties all classes at once (flag flip-flops); no clearing pass.
// ----------------------------------------------------------------------------
module equivalence_class_table #(
	parameter int VAR_COUNT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [ect_pkg::IN_W-1:0]  s_axis_tdata,   // op[2:0], var_a[8:3], var_b[14:9]
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [ect_pkg::OUT_W-1:0] m_axis_tdata    // a_in_class[0], a_rep[6:1], a_class_size[13:7]
);
	import ect_pkg::*;

	localparam int DEPTH = (VAR_COUNT < VAR_SPAN) ? VAR_COUNT : VAR_SPAN;
	localparam int IW    = $clog2(DEPTH);

	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_RDA  = 19'h00002,
		ST_RDB  = 19'h00004,
		ST_DEC  = 19'h00008,
		ST_MGB  = 19'h00010,
		ST_MGS  = 19'h00020,
		ST_RM0  = 19'h00040,
		ST_RM1  = 19'h00080,
		ST_RMC  = 19'h00100,
		ST_RM2  = 19'h00200,
		ST_RMA  = 19'h00400,
		ST_AS0  = 19'h00800,
		ST_AS1  = 19'h01000,
		ST_ASS  = 19'h02000,
		ST_ASW  = 19'h04000,
		ST_RP0  = 19'h08000,
		ST_RP1  = 19'h10000,
		ST_RPC  = 19'h20000,
		ST_OUT  = 19'h40000
	} state_t;

	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [VAR_W-1:0]  a_q, a_d, b_q, b_d;
	logic              a_ok_q, a_ok_d, b_ok_q, b_ok_d;
	logic              va_q, va_d, vb_q, vb_d;
	logic [VAR_W-1:0]  ra_q, ra_d;
	logic [VAR_W-1:0]  rmv_q, rmv_d;
	logic              cont_asg_q, cont_asg_d;
	logic [VAR_W-1:0]  r_q, r_d, to_q, to_d;
	logic              hit_q, hit_d;
	logic              out_vld_q, out_vld_d;
	logic [OUT_W-1:0]  out_data_q, out_data_d;

	logic [VAR_W-1:0]  in_a, in_b;
	logic [IW-1:0]     rd_addr, scan_addr;
	logic              rd_vld;
	logic [VAR_W-1:0]  rd_rep;
	wr_req_t           wr, fsm_wr, scan_wr;
	scan_cmd_t         scan_cmd;
	scan_rsp_t         scan_rsp;
	logic [VAR_W-1:0]  ra_n, rb_n, rb_new;

	assign in_a = s_axis_tdata[8:3];
	assign in_b = s_axis_tdata[14:9];

	assign ra_n   = va_q ? ra_q : a_q;
	assign rb_n   = rd_vld ? rd_rep : b_q;
	assign rb_new = rd_vld ? rd_rep : b_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	assign wr = (scan_wr.rep_en || scan_wr.vld_en) ? scan_wr : fsm_wr;

	ect_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_vld  (rd_vld),
		.rd_rep  (rd_rep),
		.wr      (wr)
	);

	ect_scan #(.DEPTH(DEPTH), .IW(IW)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (scan_cmd),
		.target     (r_q),
		.relabel_to (to_q),
		.rd_vld     (rd_vld),
		.rd_rep     (rd_rep),
		.addr       (scan_addr),
		.wr         (scan_wr),
		.rsp        (scan_rsp)
	);

	always_comb begin
		state_d    = state_q;
		op_d       = op_q;
		a_d        = a_q;
		b_d        = b_q;
		a_ok_d     = a_ok_q;
		b_ok_d     = b_ok_q;
		va_d       = va_q;
		vb_d       = vb_q;
		ra_d       = ra_q;
		rmv_d      = rmv_q;
		cont_asg_d = cont_asg_q;
		r_d        = r_q;
		to_d       = to_q;
		hit_d      = hit_q;
		out_vld_d  = out_vld_q && !m_axis_tready;
		out_data_d = out_data_q;
		rd_addr    = scan_addr;
		fsm_wr     = '0;
		scan_cmd   = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_d    = s_axis_tdata[2:0];
					a_d     = in_a;
					b_d     = in_b;
					a_ok_d  = int'(in_a) < VAR_COUNT;
					b_ok_d  = int'(in_b) < VAR_COUNT;
					state_d = ST_RDA;
				end
			end
			ST_RDA: begin
				rd_addr = a_q[IW-1:0];
				state_d = ST_RDB;
			end
			ST_RDB: begin
				rd_addr = b_q[IW-1:0];
				va_d    = rd_vld;
				ra_d    = rd_rep;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				vb_d    = rd_vld;
				state_d = ST_RP0;
				if (a_ok_q) begin
					case (op_q)
						OP_REMOVE: begin
							rmv_d      = a_q;
							cont_asg_d = 1'b0;
							state_d    = ST_RM0;
						end
						OP_MERGE: begin
							if (b_ok_q && a_q != b_q &&
							    !(va_q && rd_vld && ra_q == rd_rep)) begin
								fsm_wr.rep_en = !va_q;
								fsm_wr.vld_en = !va_q;
								fsm_wr.vld    = 1'b1;
								fsm_wr.rep    = a_q;
								fsm_wr.idx    = a_q;
								r_d           = (ra_n < rb_n) ? rb_n : ra_n;
								to_d          = (ra_n < rb_n) ? ra_n : rb_n;
								state_d       = ST_MGB;
							end
						end
						OP_ASSIGN, OP_RENAME: begin
							if (b_ok_q) begin
								if (a_q != b_q) begin
									rmv_d      = a_q;
									cont_asg_d = 1'b1;
									state_d    = ST_RM0;
								end else if (op_q == OP_RENAME) begin
									rmv_d      = a_q;
									cont_asg_d = 1'b0;
									state_d    = ST_RM0;
								end
							end
						end
						OP_WEAK: begin
							if (b_ok_q && va_q && !(rd_vld && rd_rep == ra_q)) begin
								rmv_d      = a_q;
								cont_asg_d = 1'b0;
								state_d    = ST_RM0;
							end
						end
						default: state_d = ST_RP0;
					endcase
				end
			end
			ST_MGB: begin
				fsm_wr.rep_en = !vb_q;
				fsm_wr.vld_en = !vb_q;
				fsm_wr.vld    = 1'b1;
				fsm_wr.rep    = b_q;
				fsm_wr.idx    = b_q;
				scan_cmd      = '{start: 1'b1, mode: SCAN_RELABEL};
				state_d       = ST_MGS;
			end
			ST_MGS: begin
				if (scan_rsp.done) begin
					state_d = ST_RP0;
				end
			end
			ST_RM0: begin
				rd_addr = rmv_q[IW-1:0];
				state_d = ST_RM1;
			end
			ST_RM1: begin
				if (!rd_vld) begin
					state_d = cont_asg_q ? ST_AS0 : ST_RP0;
				end else begin
					r_d           = rd_rep;
					fsm_wr.vld_en = 1'b1;
					fsm_wr.vld    = 1'b0;
					fsm_wr.idx    = rmv_q;
					scan_cmd      = '{start: 1'b1, mode: SCAN_COUNT};
					state_d       = ST_RMC;
				end
			end
			ST_RMC: begin
				if (scan_rsp.done) begin
					state_d = ST_RM2;
				end
			end
			ST_RM2: begin
				if (scan_rsp.cnt <= CNT_W'(1)) begin
					scan_cmd = '{start: 1'b1, mode: SCAN_CLEAR};
					state_d  = ST_RMA;
				end else if (rmv_q == r_q) begin
					to_d     = scan_rsp.min;
					scan_cmd = '{start: 1'b1, mode: SCAN_RELABEL};
					state_d  = ST_RMA;
				end else begin
					state_d = cont_asg_q ? ST_AS0 : ST_RP0;
				end
			end
			ST_RMA: begin
				if (scan_rsp.done) begin
					state_d = cont_asg_q ? ST_AS0 : ST_RP0;
				end
			end
			ST_AS0: begin
				rd_addr = b_q[IW-1:0];
				state_d = ST_AS1;
			end
			ST_AS1: begin
				fsm_wr.rep_en = !rd_vld;
				fsm_wr.vld_en = !rd_vld;
				fsm_wr.vld    = 1'b1;
				fsm_wr.rep    = b_q;
				fsm_wr.idx    = b_q;
				r_d           = rb_new;
				if (a_q < rb_new) begin
					to_d     = a_q;
					scan_cmd = '{start: 1'b1, mode: SCAN_RELABEL};
					state_d  = ST_ASS;
				end else begin
					state_d = ST_ASW;
				end
			end
			ST_ASS: begin
				if (scan_rsp.done) begin
					state_d = ST_ASW;
				end
			end
			ST_ASW: begin
				fsm_wr.rep_en = 1'b1;
				fsm_wr.vld_en = 1'b1;
				fsm_wr.vld    = 1'b1;
				fsm_wr.rep    = (a_q < r_q) ? a_q : r_q;
				fsm_wr.idx    = a_q;
				if (op_q == OP_RENAME) begin
					rmv_d      = b_q;
					cont_asg_d = 1'b0;
					state_d    = ST_RM0;
				end else begin
					state_d = ST_RP0;
				end
			end
			ST_RP0: begin
				rd_addr = a_q[IW-1:0];
				state_d = ST_RP1;
			end
			ST_RP1: begin
				if (a_ok_q && rd_vld) begin
					hit_d    = 1'b1;
					r_d      = rd_rep;
					scan_cmd = '{start: 1'b1, mode: SCAN_COUNT};
					state_d  = ST_RPC;
				end else begin
					hit_d   = 1'b0;
					state_d = ST_OUT;
				end
			end
			ST_RPC: begin
				if (scan_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_vld_q || m_axis_tready) begin
					out_vld_d  = 1'b1;
					out_data_d = hit_q ? {2'b00, scan_rsp.cnt, r_q, 1'b1} : '0;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		a_q        <= a_d;
		b_q        <= b_d;
		a_ok_q     <= a_ok_d;
		b_ok_q     <= b_ok_d;
		va_q       <= va_d;
		vb_q       <= vb_d;
		ra_q       <= ra_d;
		rmv_q      <= rmv_d;
		cont_asg_q <= cont_asg_d;
		r_q        <= r_d;
		to_q       <= to_d;
		hit_q      <= hit_d;
		out_data_q <= out_data_d;
	end

	// a variable outside any class reports all zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[13:1] == '0)
		else $error("free variable reported with class data");

	// classes never hold fewer than two members
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[13:7] >= CNT_W'(2))
		else $error("class of fewer than two members reported");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !(wr.rep_en || wr.vld_en))
		else $error("table written while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.done |-> (state_q == ST_MGS || state_q == ST_RMC || state_q == ST_RMA ||
		                   state_q == ST_ASS || state_q == ST_RPC))
		else $error("scan finished outside a scan wait state");

endmodule
